/* src/blr_pkg.sv */
// Shared codes and sizes for the line rasterizer.
// No dependencies; imported by the front end, the command queue and the back end.
`default_nettype none

package blr_pkg;

    // Item kind, as carried on the mode input and in the command queue.
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    // Command queue depth between front end and back end.
    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

/* src/blr_queue.sv */
// Small flip-flop command queue between the front end and the back end.
// Depends on blr_pkg for its depth.
`default_nettype none

module blr_queue #(
    parameter int unsigned WIDTH = 80
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import blr_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_push_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push && pop) |=> (count_reg == $past(count_reg)))
        else $error("queue count moved on simultaneous push and pop");
`endif

endmodule

`default_nettype wire

/* src/blr_front.sv */
// Front end: takes input beats, picks the major axis, orders the endpoints
// and forms the error setup. Depends on blr_pkg; feeds blr_queue.
`default_nettype none

module blr_front #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [COORD_WIDTH-1:0]            x_start,
    input  logic [COORD_WIDTH-1:0]            y_start,
    input  logic [COORD_WIDTH-1:0]            x_end,
    input  logic [COORD_WIDTH-1:0]            y_end,
    input  logic [7:0]                        colour,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output logic [6*COORD_WIDTH+19:0]         cmd_data
);
    import blr_pkg::*;

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned EW = COORD_WIDTH + 3;

    logic          xb_lt_xa;
    logic          xa_lt_xb;
    logic          yb_lt_ya;
    logic          ya_lt_yb;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic          x_major;
    logic          swap;
    logic [CW-1:0] maj_a;
    logic [CW-1:0] maj_b;
    logic [CW-1:0] min_a;
    logic [CW-1:0] min_b;
    logic [CW-1:0] maj_start;
    logic [CW-1:0] maj_stop;
    logic [CW-1:0] min_start;
    logic          step_down;
    logic [CW-1:0] maj_delta;
    logic [CW-1:0] min_delta;
    logic signed [EW-1:0] err_init;
    logic signed [EW-1:0] inc_pos;
    logic signed [EW-1:0] inc_neg;
    mode_t         kind;

    assign xb_lt_xa = x_end < x_start;
    assign xa_lt_xb = x_start < x_end;
    assign yb_lt_ya = y_end < y_start;
    assign ya_lt_yb = y_start < y_end;
    assign dx = xb_lt_xa ? (x_start - x_end) : (x_end - x_start);
    assign dy = yb_lt_ya ? (y_start - y_end) : (y_end - y_start);

    // equal deltas go to the y axis
    assign x_major = dx > dy;

    assign maj_a     = x_major ? x_start : y_start;
    assign maj_b     = x_major ? x_end   : y_end;
    assign min_a     = x_major ? y_start : x_start;
    assign min_b     = x_major ? y_end   : x_end;
    assign maj_delta = x_major ? dx : dy;
    assign min_delta = x_major ? dy : dx;
    assign swap      = x_major ? xb_lt_xa : yb_lt_ya;

    assign maj_start = swap ? maj_b : maj_a;
    assign maj_stop  = swap ? maj_a : maj_b;
    assign min_start = swap ? min_b : min_a;
    // minor direction judged after ordering
    assign step_down = swap ? (x_major ? ya_lt_yb : xa_lt_xb)
                            : (x_major ? yb_lt_ya : xb_lt_xa);

    assign inc_pos  = $signed({2'b00, min_delta, 1'b0});
    assign err_init = inc_pos - $signed({3'b000, maj_delta});
    assign inc_neg  = inc_pos - $signed({2'b00, maj_delta, 1'b0});

    assign kind = mode_t'(mode);

    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;
    assign cmd_data  = {kind, x_major, step_down, maj_start, maj_stop, min_start,
                        err_init, inc_pos, inc_neg, colour};

endmodule

`default_nettype wire

/* src/blr_back.sv */
// Back end: holds the active line, walks it one pixel per step command and
// drives the output register. Depends on blr_pkg; fed from blr_queue.
`default_nettype none

module blr_back #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic [6*COORD_WIDTH+19:0] cmd_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COORD_WIDTH-1:0]    pixel_x,
    output logic [COORD_WIDTH-1:0]    pixel_y,
    output logic [7:0]                pixel_colour,
    output logic                      last_pixel
);
    import blr_pkg::*;

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned EW = COORD_WIDTH + 3;

    mode_t                c_kind;
    logic                 c_x_major;
    logic                 c_step_down;
    logic [CW-1:0]        c_maj_start;
    logic [CW-1:0]        c_maj_stop;
    logic [CW-1:0]        c_min_start;
    logic signed [EW-1:0] c_err_init;
    logic signed [EW-1:0] c_inc_pos;
    logic signed [EW-1:0] c_inc_neg;
    logic [7:0]           c_colour;

    logic                 active_reg;
    logic                 active_next;
    logic                 x_major_reg;
    logic                 x_major_next;
    logic                 step_down_reg;
    logic                 step_down_next;
    logic [CW-1:0]        major_pos_reg;
    logic [CW-1:0]        major_pos_next;
    logic [CW-1:0]        major_end_reg;
    logic [CW-1:0]        major_end_next;
    logic [CW-1:0]        minor_pos_reg;
    logic [CW-1:0]        minor_pos_next;
    logic signed [EW-1:0] err_reg;
    logic signed [EW-1:0] err_next;
    logic signed [EW-1:0] inc_pos_reg;
    logic signed [EW-1:0] inc_pos_next;
    logic signed [EW-1:0] inc_neg_reg;
    logic signed [EW-1:0] inc_neg_next;
    logic [7:0]           colour_reg;
    logic [7:0]           colour_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CW-1:0]        pixel_x_reg;
    logic [CW-1:0]        pixel_x_next;
    logic [CW-1:0]        pixel_y_reg;
    logic [CW-1:0]        pixel_y_next;
    logic [7:0]           pixel_colour_reg;
    logic [7:0]           pixel_colour_next;
    logic                 last_pixel_reg;
    logic                 last_pixel_next;

    logic                 out_free;
    logic                 cmd_fire;
    logic                 emit;
    logic                 at_end;

    assign {c_kind, c_x_major, c_step_down, c_maj_start, c_maj_stop, c_min_start,
            c_err_init, c_inc_pos, c_inc_neg, c_colour} = cmd_data;

    assign out_free = !out_valid_reg || out_ready;
    // loads and steps with no line never touch the output register
    assign cmd_ready = (c_kind == MODE_LOAD) || !active_reg || out_free;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign emit      = cmd_fire && (c_kind == MODE_STEP) && active_reg;
    assign at_end    = (major_pos_reg == major_end_reg);

    always_comb
    begin
        active_next       = active_reg;
        x_major_next      = x_major_reg;
        step_down_next    = step_down_reg;
        major_pos_next    = major_pos_reg;
        major_end_next    = major_end_reg;
        minor_pos_next    = minor_pos_reg;
        err_next          = err_reg;
        inc_pos_next      = inc_pos_reg;
        inc_neg_next      = inc_neg_reg;
        colour_next       = colour_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        pixel_colour_next = pixel_colour_reg;
        last_pixel_next   = last_pixel_reg;

        if (cmd_fire && (c_kind == MODE_LOAD))
        begin
            active_next    = 1'b1;
            x_major_next   = c_x_major;
            step_down_next = c_step_down;
            major_pos_next = c_maj_start;
            major_end_next = c_maj_stop;
            minor_pos_next = c_min_start;
            err_next       = c_err_init;
            inc_pos_next   = c_inc_pos;
            inc_neg_next   = c_inc_neg;
            colour_next    = c_colour;
        end
        else if (emit)
        begin
            out_valid_next    = 1'b1;
            pixel_x_next      = x_major_reg ? major_pos_reg : minor_pos_reg;
            pixel_y_next      = x_major_reg ? minor_pos_reg : major_pos_reg;
            pixel_colour_next = colour_reg;
            last_pixel_next   = at_end;
            if (err_reg < 0)
            begin
                err_next = err_reg + inc_pos_reg;
            end
            else
            begin
                err_next       = err_reg + inc_neg_reg;
                minor_pos_next = step_down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
            end
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_major_reg      <= x_major_next;
        step_down_reg    <= step_down_next;
        major_pos_reg    <= major_pos_next;
        major_end_reg    <= major_end_next;
        minor_pos_reg    <= minor_pos_next;
        err_reg          <= err_next;
        inc_pos_reg      <= inc_pos_next;
        inc_neg_reg      <= inc_neg_next;
        colour_reg       <= colour_next;
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        pixel_colour_reg <= pixel_colour_next;
        last_pixel_reg   <= last_pixel_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_colour = pixel_colour_reg;
    assign last_pixel   = last_pixel_reg;

`ifndef SYNTHESIS
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && at_end) |=> (!active_reg && out_valid_reg && last_pixel_reg))
        else $error("final pixel did not close the line");

    a_load_starts_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (c_kind == MODE_LOAD)) |=> active_reg)
        else $error("load did not start a line");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("pixel issued over a waiting beat");
`endif

endmodule

`default_nettype wire

/* src/bresenham_line_raster.sv */
// Bresenham line rasterizer: front end, command queue and back end.
// Depends on blr_pkg, blr_front, blr_queue and blr_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per beat. mode low
//   loads a line from (x_start, y_start) to (x_end, y_end) in colour; mode
//   high asks for the next pixel of the current line. Loads produce no
//   output; a step with no line loaded is dropped.
//   Output channel (out_valid/out_ready) carries one pixel per beat with
//   pixel_x, pixel_y, pixel_colour and last_pixel set on the line's end.
//   Throughput: one command per cycle while the command queue has room. A step
//   beat is written into the queue, then taken by the back end, which registers
//   its pixel in the output register.
//   The four-entry command queue lets input beats keep arriving while a
//   pixel waits; in_ready drops only when the queue fills, so a stalled
//   receiver backs up into the input channel after four more commands.
//   Reset: no line is active, the queue is empty and out_valid is low.
`default_nettype none

module bresenham_line_raster #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [COORD_WIDTH-1:0] x_start,
    input  logic [COORD_WIDTH-1:0] y_start,
    input  logic [COORD_WIDTH-1:0] x_end,
    input  logic [COORD_WIDTH-1:0] y_end,
    input  logic [7:0]             colour,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] pixel_x,
    output logic [COORD_WIDTH-1:0] pixel_y,
    output logic [7:0]             pixel_colour,
    output logic                   last_pixel
);
    localparam int unsigned CMD_W = 6 * COORD_WIDTH + 20;

    logic             fe_valid;
    logic             fe_ready;
    logic [CMD_W-1:0] fe_data;
    logic             be_valid;
    logic             be_ready;
    logic [CMD_W-1:0] be_data;

    blr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .colour    (colour),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd_data  (fe_data)
    );

    blr_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_data  (fe_data),
        .rd_valid (be_valid),
        .rd_ready (be_ready),
        .rd_data  (be_data)
    );

    blr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (be_valid),
        .cmd_ready    (be_ready),
        .cmd_data     (be_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

endmodule

`default_nettype wire

/* tb/sv/bresenham_line_raster_test.sv */
// Testbench for bresenham_line_raster: a directed table, then random line commands.
// Every pixel beat is checked against a line stepper kept inside this bench or a pixel typed in the table.
// Depends on blr_pkg and the bresenham_line_raster RTL.

module bresenham_line_raster_test;

    import blr_pkg::*;

    localparam int COORD_W     = 10;
    localparam int RAND_ITEMS  = 1550;
    localparam int SQUEEZE_AT  = 500;
    localparam int TAIL_FROM   = 1400;
    localparam int DIR_COUNT   = 25;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        mode_t      mode;
        coord_t     xs;
        coord_t     ys;
        coord_t     xe;
        coord_t     ye;
        logic [7:0] colour;
    } beat_t;

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        logic [7:0] colour;
        logic       is_last;
    } pixel_t;

    // CHK_MODEL: stepper decides; CHK_NONE: no pixel; CHK_PIXEL: typed pixel
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } check_t;

    typedef struct packed {
        beat_t  b;
        check_t chk;
        pixel_t want;
    } row_t;

    localparam beat_t  STEP_BEAT = '{MODE_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 8'd0};
    localparam pixel_t NO_PIXEL  = '0;

    localparam row_t DIR_ROWS [DIR_COUNT] = '{
        '{STEP_BEAT, CHK_NONE, NO_PIXEL},
        '{'{MODE_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'hff}, CHK_NONE, NO_PIXEL},
        '{STEP_BEAT, CHK_PIXEL, '{10'd1023, 10'd1023, 8'hff, 1'b1}},
        '{STEP_BEAT, CHK_NONE, NO_PIXEL},
        '{'{MODE_LOAD, 10'd0, 10'd0, 10'd0, 10'd0, 8'h00}, CHK_NONE, NO_PIXEL},
        '{STEP_BEAT, CHK_PIXEL, '{10'd0, 10'd0, 8'h00, 1'b1}},
        // equal deltas: y major, x steps down
        '{'{MODE_LOAD, 10'd5, 10'd2, 10'd2, 10'd5, 8'h3c}, CHK_NONE, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        // x major, reversed; replaced by the next load before it ends
        '{'{MODE_LOAD, 10'd1023, 10'd0, 10'd1019, 10'd2, 8'h81}, CHK_NONE, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{'{MODE_LOAD, 10'd0, 10'd1023, 10'd2, 10'd1017, 8'h7e}, CHK_NONE, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_MODEL, NO_PIXEL},
        '{STEP_BEAT, CHK_NONE, NO_PIXEL},
        '{'{MODE_LOAD, 10'd0, 10'd0, 10'd1023, 10'd1, 8'h55}, CHK_NONE, NO_PIXEL},
        '{STEP_BEAT, CHK_PIXEL, '{10'd0, 10'd0, 8'h55, 1'b0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       mode = 1'b0;
    coord_t     x_start = '0;
    coord_t     y_start = '0;
    coord_t     x_end = '0;
    coord_t     y_end = '0;
    logic [7:0] colour = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    coord_t     pixel_x;
    coord_t     pixel_y;
    logic [7:0] pixel_colour;
    logic       last_pixel;

    // line stepper state
    coord_t            ln_major = '0;
    coord_t            ln_major_end = '0;
    coord_t            ln_minor = '0;
    logic signed [12:0] ln_err = '0;
    coord_t            ln_major_delta = '0;
    coord_t            ln_minor_delta = '0;
    logic              ln_step_down = 1'b0;
    logic              ln_x_major = 1'b0;
    logic              ln_active = 1'b0;
    logic [7:0]        ln_colour = '0;

    pixel_t pending_pixels [$];
    pixel_t got_pixel;
    pixel_t want_pixel;
    int     pixel_errors = 0;
    int     items_done = 0;
    int     rx_hold_len = 0;
    logic   quiet = 1'b0;
    int     tx_left = 0;
    int     tx_odds = 0;
    int     rx_left = 0;
    int     rx_odds = 0;

    bresenham_line_raster #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .x_start(x_start),
        .y_start(y_start),
        .x_end(x_end),
        .y_end(y_end),
        .colour(colour),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .pixel_colour(pixel_colour),
        .last_pixel(last_pixel)
    );

    always #5 clk = ~clk;

    // Applies one accepted beat to the stepper; returns 1 when it yields a pixel.
    function automatic bit step_line(input beat_t b, output pixel_t px);
        coord_t dx;
        coord_t dy;
        coord_t maj_a;
        coord_t maj_b;
        coord_t min_a;
        coord_t min_b;
        coord_t t;
        logic   at_end;
        px = '0;
        if (b.mode == MODE_LOAD)
        begin
            dx = (b.xs > b.xe) ? b.xs - b.xe : b.xe - b.xs;
            dy = (b.ys > b.ye) ? b.ys - b.ye : b.ye - b.ys;
            ln_x_major = dx > dy;
            if (ln_x_major)
            begin
                maj_a = b.xs; maj_b = b.xe; min_a = b.ys; min_b = b.ye;
                ln_major_delta = dx; ln_minor_delta = dy;
            end
            else
            begin
                maj_a = b.ys; maj_b = b.ye; min_a = b.xs; min_b = b.xe;
                ln_major_delta = dy; ln_minor_delta = dx;
            end
            if (maj_b < maj_a)
            begin
                t = maj_a; maj_a = maj_b; maj_b = t;
                t = min_a; min_a = min_b; min_b = t;
            end
            ln_major = maj_a;
            ln_major_end = maj_b;
            ln_minor = min_a;
            // direction taken after the swap
            ln_step_down = min_b < min_a;
            ln_err = 13'(2 * int'(ln_minor_delta) - int'(ln_major_delta));
            ln_colour = b.colour;
            ln_active = 1'b1;
            return 1'b0;
        end
        if (!ln_active)
            return 1'b0;
        at_end = ln_major == ln_major_end;
        px.x = ln_x_major ? ln_major : ln_minor;
        px.y = ln_x_major ? ln_minor : ln_major;
        px.colour = ln_colour;
        px.is_last = at_end;
        if (ln_err < 0)
            ln_err = ln_err + 13'(2 * int'(ln_minor_delta));
        else
        begin
            ln_err = ln_err + 13'(2 * (int'(ln_minor_delta) - int'(ln_major_delta)));
            ln_minor = ln_step_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
        end
        if (at_end)
            ln_active = 1'b0;
        else
            ln_major = ln_major + 1'b1;
        return 1'b1;
    endfunction

    // Stretches of 20..200 calls, each either calm or stalling now and then.
    function automatic int idle_burst(inout int left, inout int odds);
        if (left == 0)
        begin
            left = $urandom_range(20, 200);
            odds = $urandom_range(0, 2) * 4;
        end
        left--;
        if (odds == 0 || $urandom_range(1, odds) != 1)
            return 0;
        return $urandom_range(1, 13);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t near(input coord_t c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return coord_t'(v);
    endfunction

    function automatic beat_t rand_beat(input mode_t m);
        beat_t b;
        b.mode = m;
        b.xs = pick_coord();
        b.ys = pick_coord();
        b.xe = pick_coord();
        b.ye = pick_coord();
        b.colour = 8'($urandom);
        return b;
    endfunction

    // number of pixels in the line a load beat describes
    function automatic int line_len(input beat_t b);
        int dx;
        int dy;
        dx = int'(b.xs) - int'(b.xe);
        dy = int'(b.ys) - int'(b.ye);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    task automatic drive_beat(input row_t r, input int gap);
        pixel_t px;
        bit     hit;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode     <= r.b.mode;
        x_start  <= r.b.xs;
        y_start  <= r.b.ys;
        x_end    <= r.b.xe;
        y_end    <= r.b.ye;
        colour   <= r.b.colour;
        do
            @(posedge clk);
        while (!in_ready);
        hit = step_line(r.b, px);
        case (r.chk)
            CHK_MODEL: if (hit) pending_pixels.push_back(px);
            CHK_PIXEL: pending_pixels.push_back(r.want);
            default: ;
        endcase
        if (hit || r.b.mode == MODE_LOAD)
            items_done++;
    endtask

    // One load beat followed by n_steps step beats with random, ignored payload.
    task automatic line_beats(input beat_t ld, input int n_steps, input bit squeeze);
        row_t r;
        int   gap;
        r.chk = CHK_MODEL;
        r.want = NO_PIXEL;
        r.b = ld;
        drive_beat(r, (quiet || squeeze) ? 0 : idle_burst(tx_left, tx_odds));
        // receiver holds off while steps keep coming, so in_ready must drop
        if (squeeze)
            rx_hold_len = 80;
        for (int i = 0; i < n_steps; i++)
        begin
            r.b = rand_beat(MODE_STEP);
            gap = (quiet || squeeze) ? 0 : idle_burst(tx_left, tx_odds);
            drive_beat(r, gap);
        end
    endtask

    initial
    begin
        beat_t b;
        row_t  r;
        int    pick;
        int    span;
        int    len;
        int    n_steps;
        bit    squeeze_done;
        squeeze_done = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i])
            drive_beat(DIR_ROWS[i], idle_burst(tx_left, tx_odds));

        items_done = 0;
        while (items_done < RAND_ITEMS)
        begin
            if (items_done >= TAIL_FROM)
                quiet = 1'b1;
            if (!squeeze_done && items_done >= SQUEEZE_AT)
            begin
                squeeze_done = 1'b1;
                b = '{MODE_LOAD, 10'd100, 10'd200, 10'd160, 10'd230, 8'($urandom)};
                line_beats(b, 61, 1'b1);
                // hold the input until the output side has drained
                @(negedge clk);
                in_valid <= 1'b0;
                wait (pending_pixels.size() == 0);
            end
            pick = $urandom_range(0, 99);
            b = rand_beat(MODE_LOAD);
            if (pick < 75)
            begin
                span = $urandom_range(0, 15);
                b.xe = near(b.xs, span);
                b.ye = near(b.ys, span);
                len = line_len(b);
                case ($urandom_range(0, 9))
                    0: n_steps = $urandom_range(0, len);
                    1: n_steps = len + $urandom_range(1, 3);
                    default: n_steps = len;
                endcase
                line_beats(b, n_steps, 1'b0);
            end
            else if (pick < 92)
            begin
                // wide lines: mostly cut short by the next load
                len = line_len(b);
                n_steps = ($urandom_range(0, 24) == 0) ? len : $urandom_range(0, 40);
                line_beats(b, n_steps, 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    r.b = rand_beat(mode_t'($urandom_range(0, 1)));
                    r.chk = CHK_MODEL;
                    r.want = NO_PIXEL;
                    drive_beat(r, quiet ? 0 : idle_burst(tx_left, tx_odds));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (12) @(posedge clk);
        if (pixel_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_len - 1) @(negedge clk);
                rx_hold_len = 0;
            end
            else
            begin
                stall = quiet ? 0 : idle_burst(rx_left, rx_odds);
                if (stall == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_pixel = '{pixel_x, pixel_y, pixel_colour, last_pixel};
            if (pending_pixels.size() == 0)
            begin
                pixel_errors++;
                if (pixel_errors <= 10)
                    $display("unexpected pixel beat: x=%0d y=%0d colour=%0h last=%0b",
                             got_pixel.x, got_pixel.y, got_pixel.colour, got_pixel.is_last);
            end
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (got_pixel.x !== want_pixel.x || got_pixel.y !== want_pixel.y ||
                    got_pixel.colour !== want_pixel.colour ||
                    got_pixel.is_last !== want_pixel.is_last)
                begin
                    pixel_errors++;
                    if (pixel_errors <= 10)
                        $display("pixel mismatch: got x=%0d y=%0d colour=%0h last=%0b, %s",
                                 got_pixel.x, got_pixel.y, got_pixel.colour,
                                 got_pixel.is_last,
                                 $sformatf("expected x=%0d y=%0d colour=%0h last=%0b",
                                           want_pixel.x, want_pixel.y,
                                           want_pixel.colour, want_pixel.is_last));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
